FILE: src/sov_pkg.sv
package sov_pkg;

    // default overlay map geometry
    localparam int SOV_MAP_COLS = 160;
    localparam int SOV_MAP_ROWS = 120;

    // linear cell address width, enough for 512 x 512 cells
    localparam int SOV_LIN_W = 18;

    // queue between front and back
    localparam int SOV_Q_DEPTH = 4;
    localparam int SOV_Q_PW    = 2;

    // item modes
    localparam logic [1:0] SOV_MODE_WRITE   = 2'd0;
    localparam logic [1:0] SOV_MODE_SPRITE  = 2'd1;
    localparam logic [1:0] SOV_MODE_RESTORE = 2'd2;

    // stored cell codes
    localparam logic [1:0] SOV_CODE_EMPTY = 2'd0;
    localparam logic [1:0] SOV_CODE_ONE   = 2'd1;
    localparam logic [1:0] SOV_CODE_TWO   = 2'd2;

    // configuration register indexes
    localparam logic [2:0] SOV_REG_KEY   = 3'd0;
    localparam logic [2:0] SOV_REG_COL1  = 3'd1;
    localparam logic [2:0] SOV_REG_COL2  = 3'd2;
    localparam logic [2:0] SOV_REG_ORG_X = 3'd3;
    localparam logic [2:0] SOV_REG_ORG_Y = 3'd4;

    localparam logic [8:0] SOV_ORG_X_RST = 9'd3;
    localparam logic [8:0] SOV_ORG_Y_RST = 9'd37;

    typedef struct packed {
        logic [15:0] key;
        logic [15:0] color_one;
        logic [15:0] color_two;
        logic [8:0]  org_x;
        logic [8:0]  org_y;
    } t_cfg;

    // one classified item on its way from front to back
    typedef struct packed {
        logic [1:0]           mode;
        logic                 wr_en;
        logic                 in_map;
        logic [SOV_LIN_W-1:0] addr;
        logic [1:0]           code;
        logic [15:0]          bg;
        logic [15:0]          spr;
    } t_entry;

endpackage

FILE: src/sov_ifs.sv
interface sov_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [8:0]  screen_x;
    logic [8:0]  screen_y;
    logic [7:0]  cell_col;
    logic [6:0]  cell_row;
    logic [7:0]  cell_code;
    logic [15:0] background_pixel;
    logic [15:0] sprite_pixel;

    modport source (
        output valid, mode, screen_x, screen_y, cell_col, cell_row, cell_code,
               background_pixel, sprite_pixel,
        input  ready
    );
    modport sink (
        input  valid, mode, screen_x, screen_y, cell_col, cell_row, cell_code,
               background_pixel, sprite_pixel,
        output ready
    );
    modport mon (
        input valid, ready, mode, screen_x, screen_y, cell_col, cell_row, cell_code,
              background_pixel, sprite_pixel
    );
endinterface

interface sov_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel_color;
    logic        from_trace;
    logic        sprite_shown;

    modport source (
        output valid, pixel_color, from_trace, sprite_shown,
        input  ready
    );
    modport sink (
        input  valid, pixel_color, from_trace, sprite_shown,
        output ready
    );
    modport mon (
        input valid, ready, pixel_color, from_trace, sprite_shown
    );
endinterface

FILE: src/sov_front.sv
module sov_front #(
    parameter int MAP_COLS = sov_pkg::SOV_MAP_COLS,
    parameter int MAP_ROWS = sov_pkg::SOV_MAP_ROWS
) (
    sov_in_if.sink          i_pix,
    input  sov_pkg::t_cfg   i_cfg,
    input  logic            i_q_full,
    input  logic            i_busy,
    output logic            o_push,
    output sov_pkg::t_entry o_entry
);
    import sov_pkg::*;

    localparam logic [9:0] COLS_LIM = 10'(MAP_COLS);
    localparam logic [9:0] ROWS_LIM = 10'(MAP_ROWS);

    logic [9:0] w_dx;
    logic [9:0] w_dy;
    logic [7:0] w_mx;
    logic [7:0] w_my;
    logic       w_x_ok;
    logic       w_y_ok;
    logic       w_is_pix;
    logic       w_is_wr;
    logic       w_wr_ok;
    logic [7:0] w_row_sel;
    logic [7:0] w_col_sel;
    logic [SOV_LIN_W-1:0] w_lin;

    assign i_pix.ready = !i_q_full && !i_busy;
    assign o_push      = i_pix.valid && i_pix.ready;

    // offset from origin, halved toward zero: -1 still lands on cell 0
    assign w_dx   = {1'b0, i_pix.screen_x} - {1'b0, i_cfg.org_x};
    assign w_dy   = {1'b0, i_pix.screen_y} - {1'b0, i_cfg.org_y};
    assign w_mx   = w_dx[9] ? 8'd0 : w_dx[8:1];
    assign w_my   = w_dy[9] ? 8'd0 : w_dy[8:1];
    assign w_x_ok = (!w_dx[9] || (w_dx == '1)) && ({2'b00, w_mx} < COLS_LIM);
    assign w_y_ok = (!w_dy[9] || (w_dy == '1)) && ({2'b00, w_my} < ROWS_LIM);

    assign w_is_wr  = (i_pix.mode == SOV_MODE_WRITE);
    assign w_is_pix = (i_pix.mode == SOV_MODE_SPRITE) || (i_pix.mode == SOV_MODE_RESTORE);
    assign w_wr_ok  = ({2'b00, i_pix.cell_col} < COLS_LIM)
                   && ({3'b000, i_pix.cell_row} < ROWS_LIM);

    assign w_row_sel = w_is_wr ? {1'b0, i_pix.cell_row} : w_my;
    assign w_col_sel = w_is_wr ? i_pix.cell_col : w_mx;
    assign w_lin = (SOV_LIN_W'(w_row_sel) * SOV_LIN_W'(MAP_COLS)) + SOV_LIN_W'(w_col_sel);

    always_comb begin
        o_entry.mode   = i_pix.mode;
        o_entry.wr_en  = w_is_wr && w_wr_ok;
        o_entry.in_map = w_is_pix && w_x_ok && w_y_ok;
        o_entry.addr   = w_lin;
        o_entry.bg     = i_pix.background_pixel;
        o_entry.spr    = i_pix.sprite_pixel;
        if (i_pix.cell_code == 8'd0) begin
            o_entry.code = SOV_CODE_EMPTY;
        end else if (i_pix.cell_code == 8'd1) begin
            o_entry.code = SOV_CODE_ONE;
        end else begin
            o_entry.code = SOV_CODE_TWO;
        end
    end

endmodule

FILE: src/sov_queue.sv
module sov_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sov_pkg::t_entry i_entry,
    input  logic            i_pop,
    output sov_pkg::t_entry o_entry,
    output logic            o_full,
    output logic            o_empty
);
    import sov_pkg::*;

    t_entry              r_slot [SOV_Q_DEPTH];
    logic [SOV_Q_PW-1:0] r_wr_ptr;
    logic [SOV_Q_PW-1:0] r_rd_ptr;
    logic [SOV_Q_PW:0]   r_count;
    logic [SOV_Q_PW-1:0] n_wr_ptr;
    logic [SOV_Q_PW-1:0] n_rd_ptr;
    logic [SOV_Q_PW:0]   n_count;

    assign o_full  = (r_count == (SOV_Q_PW+1)'(SOV_Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

endmodule

FILE: src/sov_back.sv
module sov_back #(
    parameter int MAP_COLS = sov_pkg::SOV_MAP_COLS,
    parameter int MAP_ROWS = sov_pkg::SOV_MAP_ROWS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sov_pkg::t_cfg   i_cfg,
    input  sov_pkg::t_entry i_entry,
    input  logic            i_q_empty,
    output logic            o_pop,
    output logic            o_busy,
    sov_out_if.source       o_pix
);
    import sov_pkg::*;

    localparam int DEPTH = MAP_COLS * MAP_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [1:0]    r_mem [DEPTH];
    logic [1:0]    r_rd_data;
    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;
    logic          r_s1_valid;
    t_entry        r_s1;
    logic          r_out_valid;
    logic [15:0]   r_out_color;
    logic          r_out_trace;
    logic          r_out_shown;

    logic          w_out_free;
    logic          w_s1_adv;
    logic          w_we;
    logic [AW-1:0] w_wa;
    logic [1:0]    w_wd;
    logic          w_re;
    logic [15:0]   n_color;
    logic          n_trace;
    logic          n_shown;

    assign o_busy     = r_clearing;
    assign w_out_free = !r_out_valid || o_pix.ready;
    assign w_s1_adv   = r_s1_valid && w_out_free;
    assign o_pop      = !i_q_empty && !r_clearing && (!r_s1_valid || w_s1_adv);

    // clearing sweep owns the write port after reset
    assign w_we = r_clearing || (o_pop && i_entry.wr_en);
    assign w_wa = r_clearing ? r_clr_addr : i_entry.addr[AW-1:0];
    assign w_wd = r_clearing ? SOV_CODE_EMPTY : i_entry.code;
    assign w_re = o_pop && i_entry.in_map;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (w_re) begin
            r_rd_data <= r_mem[i_entry.addr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // underlay, then color-key sprite on top
    always_comb begin
        n_color = 16'd0;
        n_trace = 1'b0;
        n_shown = 1'b0;
        if ((r_s1.mode == SOV_MODE_SPRITE) || (r_s1.mode == SOV_MODE_RESTORE)) begin
            n_color = r_s1.bg;
            if (r_s1.in_map && (r_rd_data != SOV_CODE_EMPTY)) begin
                n_color = (r_rd_data == SOV_CODE_ONE) ? i_cfg.color_one : i_cfg.color_two;
                n_trace = 1'b1;
            end
            if ((r_s1.mode == SOV_MODE_SPRITE) && (r_s1.spr != i_cfg.key)) begin
                n_color = r_s1.spr;
                n_shown = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= o_pop || (r_s1_valid && !w_s1_adv);
            r_out_valid <= w_s1_adv || (r_out_valid && !o_pix.ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1 <= i_entry;
        end
        if (w_s1_adv) begin
            r_out_color <= n_color;
            r_out_trace <= n_trace;
            r_out_shown <= n_shown;
        end
    end

    assign o_pix.valid        = r_out_valid;
    assign o_pix.pixel_color  = r_out_color;
    assign o_pix.from_trace   = r_out_trace;
    assign o_pix.sprite_shown = r_out_shown;

endmodule

FILE: src/sprite_overlay_compositor.sv
// color-key sprite compositor for rgb565 pixels with a 2-bit overlay map
//
// channels: i_pix carries one item per transfer (valid/ready); mode 0 writes
// one overlay cell, mode 1 composes a sprite pixel, mode 2 restores the
// background; every item yields exactly one transfer on o_pix, all zero for
// cell writes and unused modes
// config: i_cfg_we/i_cfg_index/i_cfg_data write one register per cycle; the
// user must write only while no item is in flight, which the block itself
// does not enforce; indexes beyond the list are dropped
// throughput: one item per cycle sustained while o_pix is ready, set by the
// single-port cell memory which serves one read or one write per cycle
// path: front classifies into the queue, back reads the map, output register
// reset: synchronous, active low; clears control state, loads register
// defaults, then sweeps all MAP_COLS * MAP_ROWS map cells (19200 at the default
// size) to empty at one cell per cycle; i_pix.ready stays low during the
// sweep, config writes are taken as usual
// stall: o_pix holds its result while ready is low; the four-entry queue and
// the map-read stage register keep accepting until the queue fills
module sprite_overlay_compositor #(
    parameter int MAP_COLS = sov_pkg::SOV_MAP_COLS,
    parameter int MAP_ROWS = sov_pkg::SOV_MAP_ROWS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sov_in_if.sink      i_pix,
    sov_out_if.source   o_pix,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import sov_pkg::*;

    t_cfg   r_cfg;
    t_entry w_push_entry;
    t_entry w_head_entry;
    logic   w_push;
    logic   w_pop;
    logic   w_q_full;
    logic   w_q_empty;
    logic   w_busy;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.key       <= 16'd0;
            r_cfg.color_one <= 16'd0;
            r_cfg.color_two <= 16'd0;
            r_cfg.org_x     <= SOV_ORG_X_RST;
            r_cfg.org_y     <= SOV_ORG_Y_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                SOV_REG_KEY:   r_cfg.key       <= i_cfg_data;
                SOV_REG_COL1:  r_cfg.color_one <= i_cfg_data;
                SOV_REG_COL2:  r_cfg.color_two <= i_cfg_data;
                SOV_REG_ORG_X: r_cfg.org_x     <= i_cfg_data[8:0];
                SOV_REG_ORG_Y: r_cfg.org_y     <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // front: address math and classification
    sov_front #(
        .MAP_COLS (MAP_COLS),
        .MAP_ROWS (MAP_ROWS)
    ) u_front (
        .i_pix    (i_pix),
        .i_cfg    (r_cfg),
        .i_q_full (w_q_full),
        .i_busy   (w_busy),
        .o_push   (w_push),
        .o_entry  (w_push_entry)
    );

    // decoupling queue
    sov_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_entry (w_head_entry),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    // back: map access, composition, output register
    sov_back #(
        .MAP_COLS (MAP_COLS),
        .MAP_ROWS (MAP_ROWS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_entry   (w_head_entry),
        .i_q_empty (w_q_empty),
        .o_pop     (w_pop),
        .o_busy    (w_busy),
        .o_pix     (o_pix)
    );

endmodule

FILE: src/sov_checker.sv
module sov_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_out_color,
    input logic        i_out_trace,
    input logic        i_out_shown
);

    // reset empties the output stage
    a_rst_out_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result presented right after reset");

    // reset starts the map sweep, so no item is taken
    a_rst_in_block: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("item accepted right after reset");

    // a stalled result stays up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // and keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_color) && $stable(i_out_trace)
            && $stable(i_out_shown))
        else $error("result changed while stalled");

endmodule

bind sprite_overlay_compositor sov_checker u_sov_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_out_color (o_pix.pixel_color),
    .i_out_trace (o_pix.from_trace),
    .i_out_shown (o_pix.sprite_shown)
);

FILE: tb/sprite_overlay_compositor_tb.sv
module sprite_overlay_compositor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sov_pkg::*;

    // codes the package leaves out
    localparam logic [1:0] MODE_UNUSED      = 2'd3;
    localparam logic [2:0] REG_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] REG_LAST_UNUSED  = 3'd7;

    localparam int MAP_CELLS = SOV_MAP_COLS * SOV_MAP_ROWS;

    // one input item as driven on the pixel channel
    typedef struct {
        logic [1:0]  mode;
        logic [8:0]  x;
        logic [8:0]  y;
        logic [7:0]  col;
        logic [6:0]  row;
        logic [7:0]  code;
        logic [15:0] bg;
        logic [15:0] spr;
    } t_pix_item;

    // one composed pixel as seen on the result channel
    typedef struct {
        logic [15:0] color;
        logic        trace;
        logic        shown;
    } t_pix_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    sov_in_if  pix_in_bus ();
    sov_out_if pix_out_bus ();

    sprite_overlay_compositor DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (pix_in_bus),
        .o_pix       (pix_out_bus),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state: its own copy of the overlay map and the registers
    logic [1:0]  cell_map [MAP_CELLS];
    t_cfg        cfg_shadow;

    // composed pixels still owed by the block, oldest first
    t_pix_result expected_pixels [$];

    int mismatch_count = 0;

    // idling controls, changed per test
    logic send_idle;
    logic recv_idle;
    logic hold_off;
    int   stall_left = 0;

    // window of map cells that most random traffic targets
    int hot_col;
    int hot_row;

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("mismatch %s: expected %0h got %0h at %0t", what, want, got, $realtime);
        mismatch_count++;
    endtask

    // predict one item, updating the overlay map for cell writes
    function automatic t_pix_result predict_pixel(input t_pix_item it);
        t_pix_result r;
        int          cx;
        int          cy;
        logic [1:0]  stored;
        r.color = '0;
        r.trace = 1'b0;
        r.shown = 1'b0;
        case (it.mode)
            SOV_MODE_WRITE: begin
                // writes outside the map are dropped
                if (it.col < SOV_MAP_COLS && it.row < SOV_MAP_ROWS) begin
                    if (it.code == 8'd0)
                        cell_map[int'(it.row) * SOV_MAP_COLS + int'(it.col)] = SOV_CODE_EMPTY;
                    else if (it.code == 8'd1)
                        cell_map[int'(it.row) * SOV_MAP_COLS + int'(it.col)] = SOV_CODE_ONE;
                    else
                        cell_map[int'(it.row) * SOV_MAP_COLS + int'(it.col)] = SOV_CODE_TWO;
                end
            end
            SOV_MODE_SPRITE, SOV_MODE_RESTORE: begin
                r.color = it.bg;
                // division truncates toward zero, so offset -1 lands in cell 0
                cx = (int'(it.x) - int'(cfg_shadow.org_x)) / 2;
                cy = (int'(it.y) - int'(cfg_shadow.org_y)) / 2;
                if (cx >= 0 && cx < SOV_MAP_COLS && cy >= 0 && cy < SOV_MAP_ROWS) begin
                    stored = cell_map[cy * SOV_MAP_COLS + cx];
                    if (stored != SOV_CODE_EMPTY) begin
                        r.color = (stored == SOV_CODE_ONE) ? cfg_shadow.color_one
                                                           : cfg_shadow.color_two;
                        r.trace = 1'b1;
                    end
                end
                // sprite replaces the underlay unless it matches the key
                if (it.mode == SOV_MODE_SPRITE && it.spr != cfg_shadow.key) begin
                    r.color = it.spr;
                    r.shown = 1'b1;
                end
            end
            default: begin
                // unused mode: all-zero result, no state change
            end
        endcase
        return r;
    endfunction

    function automatic t_pix_item make_item(input logic [1:0] mode, input int x, input int y,
                                            input int col, input int row, input int code,
                                            input logic [15:0] bg, input logic [15:0] spr);
        t_pix_item it;
        it.mode = mode;
        it.x    = 9'(x);
        it.y    = 9'(y);
        it.col  = 8'(col);
        it.row  = 7'(row);
        it.code = 8'(code);
        it.bg   = bg;
        it.spr  = spr;
        return it;
    endfunction

    // random item, mostly writes and pixels on the hot window
    function automatic t_pix_item draw_item();
        t_pix_item it;
        int        sel;
        int        cx;
        int        cy;
        it.mode = ($urandom_range(0, 1) != 0) ? SOV_MODE_SPRITE : SOV_MODE_RESTORE;
        it.x    = 9'($urandom);
        it.y    = 9'($urandom);
        it.col  = 8'($urandom);
        it.row  = 7'($urandom);
        it.code = 8'($urandom);
        it.bg   = 16'($urandom);
        it.spr  = 16'($urandom);
        sel = $urandom_range(0, 99);
        cx  = hot_col + int'($urandom_range(0, 9));
        cy  = hot_row + int'($urandom_range(0, 9));
        if (sel < 30) begin
            // cell write near the window, mostly small codes
            it.mode = SOV_MODE_WRITE;
            it.col  = 8'(cx);
            it.row  = 7'(cy);
            it.code = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(3, 255))
                                                  : 8'($urandom_range(0, 2));
        end else if (sel < 80) begin
            // pixel over the window, one screen step either side of the cell
            it.x = 9'(int'(cfg_shadow.org_x) + 2 * cx + int'($urandom_range(0, 2)) - 1);
            it.y = 9'(int'(cfg_shadow.org_y) + 2 * cy + int'($urandom_range(0, 2)) - 1);
            if ($urandom_range(0, 2) == 0)
                it.spr = cfg_shadow.key;
        end else if (sel < 90) begin
            // pixel anywhere on screen
            if ($urandom_range(0, 3) == 0)
                it.spr = cfg_shadow.key;
        end else if (sel < 95) begin
            // cell write anywhere the fields reach
            it.mode = SOV_MODE_WRITE;
        end else begin
            it.mode = MODE_UNUSED;
        end
        return it;
    endfunction

    // offer one item, wait for its transfer, then record what it must give
    task automatic send_item(input t_pix_item it);
        int gap;
        gap = send_idle ? int'($urandom_range(0, 8)) : 0;
        if (gap > 0) begin
            pix_in_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_in_bus.valid            <= 1'b1;
        pix_in_bus.mode             <= it.mode;
        pix_in_bus.screen_x         <= it.x;
        pix_in_bus.screen_y         <= it.y;
        pix_in_bus.cell_col         <= it.col;
        pix_in_bus.cell_row         <= it.row;
        pix_in_bus.cell_code        <= it.code;
        pix_in_bus.background_pixel <= it.bg;
        pix_in_bus.sprite_pixel     <= it.spr;
        @(posedge i_clk);
        while (!pix_in_bus.ready) @(posedge i_clk);
        expected_pixels.push_back(predict_pixel(it));
    endtask

    // drop valid and let every owed result drain, plus the pipeline depth
    task automatic wait_idle();
        pix_in_bus.valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // one register write; the enable drops for a cycle after each
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            SOV_REG_KEY:   cfg_shadow.key       = data;
            SOV_REG_COL1:  cfg_shadow.color_one = data;
            SOV_REG_COL2:  cfg_shadow.color_two = data;
            SOV_REG_ORG_X: cfg_shadow.org_x     = data[8:0];
            SOV_REG_ORG_Y: cfg_shadow.org_y     = data[8:0];
            default: begin
                // unknown index, ignored
            end
        endcase
    endtask

    function automatic logic [15:0] draw_color();
        case ($urandom_range(0, 3))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // origin with junk above bit 8, which the block must discard
    function automatic logic [15:0] draw_origin();
        logic [8:0] org;
        org = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 511))
                                          : 9'($urandom_range(0, 120));
        return {7'($urandom), org};
    endfunction

    // result side: checks each transfer, then draws its next stall
    always @(posedge i_clk) begin : result_check
        t_pix_result want;
        if (i_rst_n === 1'b1 && pix_out_bus.valid === 1'b1 && pix_out_bus.ready === 1'b1) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch("result with nothing owed", 0, int'(pix_out_bus.pixel_color));
            end else begin
                want = expected_pixels.pop_front();
                if (pix_out_bus.pixel_color !== want.color)
                    report_mismatch("pixel_color", int'(want.color),
                                    int'(pix_out_bus.pixel_color));
                if (pix_out_bus.from_trace !== want.trace)
                    report_mismatch("from_trace", int'(want.trace),
                                    int'(pix_out_bus.from_trace));
                if (pix_out_bus.sprite_shown !== want.shown)
                    report_mismatch("sprite_shown", int'(want.shown),
                                    int'(pix_out_bus.sprite_shown));
            end
            stall_left = recv_idle ? int'($urandom_range(0, 8)) : 0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
        end
        pix_out_bus.ready <= (stall_left == 0) && !hold_off;
    end

    // register defaults straight out of reset, overlay map already swept
    task automatic test_reset_defaults();
        send_item(make_item(SOV_MODE_WRITE, 0, 0, 0, 0, 1, 16'h0, 16'h0));
        // sprite equals the default key of zero, cell shows the default color
        send_item(make_item(SOV_MODE_SPRITE, 3, 37, 0, 0, 0, 16'h1234, 16'h0000));
        send_item(make_item(SOV_MODE_RESTORE, 4, 38, 0, 0, 0, 16'h4321, 16'h5555));
        // a pixel well inside the map on a cell never written
        send_item(make_item(SOV_MODE_RESTORE, 101, 99, 0, 0, 0, 16'hBEEF, 16'h0));
        wait_idle();
    endtask

    // extremes of the fields and each corner of the behavior
    task automatic test_directed();
        write_reg(SOV_REG_KEY, 16'hF81F);
        write_reg(SOV_REG_COL1, 16'h07E0);
        write_reg(SOV_REG_COL2, 16'h001F);
        write_reg(REG_FIRST_UNUSED, 16'hFFFF);
        // last map cell, code above 2 folds to trace two
        send_item(make_item(SOV_MODE_WRITE, 0, 0, 159, 119, 200, 16'hFFFF, 16'hFFFF));
        // writes just past each edge and at the field maxima
        send_item(make_item(SOV_MODE_WRITE, 0, 0, 160, 0, 1, 16'h0, 16'h0));
        send_item(make_item(SOV_MODE_WRITE, 0, 0, 0, 120, 2, 16'h0, 16'h0));
        send_item(make_item(SOV_MODE_WRITE, 511, 511, 255, 127, 255, 16'hFFFF, 16'hFFFF));
        send_item(make_item(SOV_MODE_WRITE, 0, 0, 1, 0, 2, 16'h0, 16'h0));
        // transparent sprite over trace one
        send_item(make_item(SOV_MODE_SPRITE, 3, 37, 0, 0, 0, 16'h1111, 16'hF81F));
        // one step before the origin still maps to cell 0
        send_item(make_item(SOV_MODE_SPRITE, 2, 36, 0, 0, 0, 16'h2222, 16'hF81F));
        // two steps before the origin falls off the map
        send_item(make_item(SOV_MODE_RESTORE, 1, 37, 0, 0, 0, 16'h3333, 16'hF81F));
        // restore over the last cell ignores the sprite
        send_item(make_item(SOV_MODE_RESTORE, 321, 275, 0, 0, 0, 16'h4444, 16'hFFFF));
        // one cell past the last column
        send_item(make_item(SOV_MODE_RESTORE, 323, 275, 0, 0, 0, 16'h5555, 16'h0));
        // opaque sprite over trace two
        send_item(make_item(SOV_MODE_SPRITE, 5, 37, 0, 0, 0, 16'h6666, 16'hABCD));
        send_item(make_item(SOV_MODE_SPRITE, 511, 511, 0, 0, 0, 16'h0000, 16'hFFFF));
        send_item(make_item(SOV_MODE_SPRITE, 0, 0, 0, 0, 0, 16'hFFFF, 16'h0000));
        send_item(make_item(SOV_MODE_RESTORE, 511, 511, 0, 0, 0, 16'hFFFF, 16'h0000));
        // unused mode with every field at its maximum, then at zero
        send_item(make_item(MODE_UNUSED, 511, 511, 255, 127, 255, 16'hFFFF, 16'hFFFF));
        send_item(make_item(MODE_UNUSED, 0, 0, 0, 0, 0, 16'h0, 16'h0));
        // clearing a cell brings the background back
        send_item(make_item(SOV_MODE_WRITE, 0, 0, 0, 0, 0, 16'h0, 16'h0));
        send_item(make_item(SOV_MODE_SPRITE, 3, 37, 0, 0, 0, 16'h7777, 16'hF81F));
        wait_idle();
    endtask

    // result side holds off while items keep coming, so the input stalls
    task automatic test_backpressure();
        send_idle <= 1'b0;
        recv_idle <= 1'b0;
        hot_col = 40;
        hot_row = 30;
        fork
            begin
                hold_off <= 1'b1;
                repeat (80) @(posedge i_clk);
                hold_off <= 1'b0;
            end
            begin
                repeat (40) send_item(draw_item());
            end
        join
        wait_idle();
    endtask

    // register settings per phase, the extremes among them
    task automatic configure_phase(input int phase);
        case (phase)
            1: begin
                write_reg(SOV_REG_KEY, 16'h0000);
                write_reg(SOV_REG_COL1, 16'hFFFF);
                write_reg(SOV_REG_COL2, 16'hFFFF);
                write_reg(SOV_REG_ORG_X, 16'h0000);
                write_reg(SOV_REG_ORG_Y, 16'h0000);
            end
            2: begin
                write_reg(SOV_REG_KEY, 16'hFFFF);
                write_reg(SOV_REG_COL1, 16'h0000);
                write_reg(SOV_REG_COL2, 16'h0000);
                write_reg(SOV_REG_ORG_X, 16'hFFFF);
                write_reg(SOV_REG_ORG_Y, 16'h01FF);
            end
            default: begin
                write_reg(SOV_REG_KEY, draw_color());
                write_reg(SOV_REG_COL1, draw_color());
                write_reg(SOV_REG_COL2, draw_color());
                write_reg(SOV_REG_ORG_X, draw_origin());
                write_reg(SOV_REG_ORG_Y, draw_origin());
            end
        endcase
        write_reg(3'($urandom_range(REG_FIRST_UNUSED, REG_LAST_UNUSED)), 16'($urandom));
    endtask

    // random traffic in phases, each with its own settings and idling
    task automatic test_random();
        for (int phase = 0; phase < 6; phase++) begin
            configure_phase(phase);
            // mix of idle-free, one-sided and two-sided idling
            send_idle <= (phase != 0) && (phase != 3);
            recv_idle <= (phase != 0) && (phase != 4);
            hot_col = (phase == 5) ? 150 : int'($urandom_range(0, 155));
            hot_row = (phase == 5) ? 110 : int'($urandom_range(0, 115));
            repeat (300) send_item(draw_item());
            wait_idle();
        end
    endtask

    initial begin
        i_rst_n                     = 1'b0;
        cfg_we                      = 1'b0;
        cfg_index                   = '0;
        cfg_data                    = '0;
        pix_in_bus.valid            = 1'b0;
        pix_in_bus.mode             = '0;
        pix_in_bus.screen_x         = '0;
        pix_in_bus.screen_y         = '0;
        pix_in_bus.cell_col         = '0;
        pix_in_bus.cell_row         = '0;
        pix_in_bus.cell_code        = '0;
        pix_in_bus.background_pixel = '0;
        pix_in_bus.sprite_pixel     = '0;
        pix_out_bus.ready           = 1'b0;
        hold_off                    = 1'b0;
        send_idle                   = 1'b1;
        recv_idle                   = 1'b1;
        hot_col                     = 0;
        hot_row                     = 0;
        foreach (cell_map[i]) cell_map[i] = SOV_CODE_EMPTY;
        cfg_shadow.key       = 16'h0000;
        cfg_shadow.color_one = 16'h0000;
        cfg_shadow.color_two = 16'h0000;
        cfg_shadow.org_x     = SOV_ORG_X_RST;
        cfg_shadow.org_y     = SOV_ORG_Y_RST;

        // hold reset, then release it; the map sweep then holds the input off
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_directed();
        test_backpressure();
        test_random();

        // all owed results are in; give stray transfers time to show up
        pix_in_bus.valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog, far beyond the slowest correct run including the sweep
    initial begin
        #3_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
